### hdl/psba_pkg.sv
// Package: constants, codes and types for the paged staging bump allocator
package psba_pkg;
    localparam int FRAME_SLOTS        = 2;
    localparam int MAX_PAGES_PER_SLOT = 8;
    localparam int SIZE_BITS          = 32;
    localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int PAGE_W = (MAX_PAGES_PER_SLOT > 1) ? $clog2(MAX_PAGES_PER_SLOT) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES_PER_SLOT + 1);
    localparam int HEAD_W = SIZE_BITS + 1;
    localparam int SUM_W  = 37;
    localparam int ALIGN_W = 17;

    typedef enum logic [1:0] {
        CMD_BEGIN   = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_END     = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_NOT_REC    = 3'd2,
        ST_EXHAUSTED  = 3'd3,
        ST_BAD_FRAME  = 3'd4
    } status_t;

    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_MAXPG  = 2'd1;
    localparam logic [1:0] REG_GROWTH = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  frame;
        logic [31:0] req_size;
        logic [16:0] req_align;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  page_index;
        logic [31:0] offset;
        logic        grew;
        logic [36:0] used_total;
        logic [3:0]  pages_held;
        logic [36:0] capacity_total;
        logic [3:0]  growth_events;
    } rsp_t;
endpackage

### hdl/psba_if.sv
// Interfaces: request and response channels
interface psba_req_if;
    import psba_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface psba_rsp_if;
    import psba_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/paged_staging_bump_allocator.sv
// Sequence: decode; each page searched runs load, 33 remainder steps and a fit check;
// grow or exhaust if no page fits; then a capacity sum over each page held.
// Begin/end and other non-search words go from decode to the sum; a bad frame goes straight out.
// Throughput: one word at a time; ready the cycle after the result is taken, bar APB writes.
// Reset: rst_n async low; registers 65536/8/1, slots cleared by a sweep of the page
// entries after reset or any accepted write to one of the three registers.
module paged_staging_bump_allocator
    import psba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    psba_req_if.sink    req,
    psba_rsp_if.source  rsp
);
    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DEC   = 9'b000000100,
        S_LOAD  = 9'b000001000,
        S_REM   = 9'b000010000,
        S_FIT   = 9'b000100000,
        S_GROW  = 9'b001000000,
        S_SUM   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    localparam int ENT = FRAME_SLOTS * MAX_PAGES_PER_SLOT;
    localparam int ENT_W = $clog2(ENT);

    state_t state_reg, state_next;
    logic [31:0] base_reg;
    logic [3:0]  maxpg_reg;
    logic        growth_en_reg;

    logic [HEAD_W-1:0] head_mem [ENT];
    logic [HEAD_W-1:0] cap_mem  [ENT];
    logic [CNT_W-1:0]  count_reg [FRAME_SLOTS];
    logic              rec_reg   [FRAME_SLOTS];
    logic [SUM_W-1:0]  used_reg  [FRAME_SLOTS];
    logic [3:0]        grow_reg  [FRAME_SLOTS];

    req_t              cur_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  pg_reg;
    logic [HEAD_W-1:0] head_reg, cap_reg;
    logic [HEAD_W-1:0] rem_reg;
    logic [5:0]        bit_reg;
    logic [HEAD_W+ALIGN_W-1:0] dvd_reg;
    logic [SUM_W-1:0]  sum_reg;
    rsp_t              out_reg;
    logic [PAGE_W:0]   init_cnt_reg;

    logic cfg_wr;
    logic cfg_take;
    logic cfg_hit;
    logic cfg_init;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    // register writes land only while no word is in flight
    assign cfg_take = cfg_wr && (state_reg == S_IDLE || state_reg == S_INIT);
    assign cfg_hit  = (paddr[3:2] == REG_BASE) || (paddr[3:2] == REG_MAXPG)
                   || (paddr[3:2] == REG_GROWTH);
    assign cfg_init = cfg_take && cfg_hit;

    always_comb
    begin
        case (paddr[3:2])
            REG_BASE:   prdata = base_reg;
            REG_MAXPG:  prdata = {28'd0, maxpg_reg};
            REG_GROWTH: prdata = {31'd0, growth_en_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // effective config
    logic [HEAD_W-1:0] eff_base;
    logic [CNT_W-1:0]  eff_max;
    assign eff_base = (base_reg == 32'd0) ? HEAD_W'(1) : HEAD_W'(base_reg);
    always_comb
    begin
        if (maxpg_reg == 4'd0)
            eff_max = CNT_W'(1);
        else if (32'(maxpg_reg) > MAX_PAGES_PER_SLOT)
            eff_max = CNT_W'(MAX_PAGES_PER_SLOT);
        else
            eff_max = CNT_W'(maxpg_reg);
    end

    logic [HEAD_W-1:0] align_eff;
    assign align_eff = (cur_reg.req_align == '0) ? HEAD_W'(1) : HEAD_W'(cur_reg.req_align);

    logic [ENT_W-1:0] ent_idx;
    assign ent_idx = ENT_W'({slot_reg, pg_reg[PAGE_W-1:0]});

    // subtractor for the remainder step; the fit check uses its own comparators
    logic [HEAD_W:0] sub_a, sub_b, sub_d;
    logic [HEAD_W-1:0] rem_shift;
    assign rem_shift = {rem_reg[HEAD_W-2:0], dvd_reg[HEAD_W+ALIGN_W-1]};
    always_comb
    begin
        if (state_reg == S_REM)
        begin
            sub_a = {1'b0, rem_shift};
            sub_b = {1'b0, align_eff};
        end
        else
        begin
            sub_a = {1'b0, cap_reg};
            sub_b = {1'b0, head_reg};
        end
    end
    assign sub_d = sub_a - sub_b;

    // aligned offset from remainder (rem_reg holds head % align in S_FIT)
    logic [HEAD_W+1:0] off_full;
    assign off_full = (rem_reg == '0) ? {2'b0, head_reg}
                    : {2'b0, head_reg} + {2'b0, align_eff} - {2'b0, rem_reg};
    logic fits;
    assign fits = (off_full <= {2'b0, cap_reg})
               && ({3'b0, cur_reg.req_size} <= ({2'b0, cap_reg} - off_full));

    // next power of two of size: smear size-1 right, then add one
    logic [SIZE_BITS-1:0] size_smear;
    logic [HEAD_W-1:0] p2;
    always_comb
    begin
        size_smear = cur_reg.req_size - 1'b1;
        for (int k = 1; k < SIZE_BITS; k = k * 2)
            size_smear = size_smear | (size_smear >> k);
        p2 = HEAD_W'(size_smear) + HEAD_W'(1);
    end
    logic [HEAD_W-1:0] new_cap;
    assign new_cap = (p2 < eff_base) ? eff_base : p2;

    assign req.ready = (state_reg == S_IDLE) && !cfg_wr;
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.data  = out_reg;

    logic slot_ok;
    assign slot_ok = 32'(cur_reg.frame) < FRAME_SLOTS;

    status_t dec_status;
    always_comb
    begin
        if (cur_reg.cmd == CMD_RESERVE && cur_reg.req_size == '0)
            dec_status = ST_ZERO_SIZE;
        else if (!slot_ok)
            dec_status = ST_BAD_FRAME;
        else if ((cur_reg.cmd == CMD_RESERVE || cur_reg.cmd == CMD_END) && !rec_reg[slot_reg])
            dec_status = ST_NOT_REC;
        else
            dec_status = ST_OK;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
                if (cfg_init) state_next = S_INIT;
                else if (init_cnt_reg == (PAGE_W+1)'(MAX_PAGES_PER_SLOT - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (cfg_init) state_next = S_INIT;
                else if (req.valid && req.ready) state_next = S_DEC;
            S_DEC:
                if (cur_reg.cmd == CMD_RESERVE && cur_reg.req_size != '0 && slot_ok
                    && rec_reg[slot_reg])
                    state_next = (count_reg[slot_reg] != '0) ? S_LOAD : S_GROW;
                else
                    state_next = slot_ok ? S_SUM : S_OUT;
            S_LOAD: state_next = S_REM;
            S_REM:  if (bit_reg == 6'd0) state_next = S_FIT;
            S_FIT:
                if (fits) state_next = S_SUM;
                else if (pg_reg + 1'b1 < count_reg[slot_reg]) state_next = S_LOAD;
                else state_next = S_GROW;
            S_GROW: state_next = S_SUM;
            S_SUM:  if (pg_reg + 1'b1 >= count_reg[slot_reg]) state_next = S_OUT;
            S_OUT:  if (rsp.ready) state_next = S_IDLE;
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            base_reg      <= 32'd65536;
            maxpg_reg     <= 4'd8;
            growth_en_reg <= 1'b1;
            init_cnt_reg  <= '0;
            for (int s = 0; s < FRAME_SLOTS; s++)
            begin
                count_reg[s] <= CNT_W'(1);
                rec_reg[s]   <= 1'b0;
                used_reg[s]  <= '0;
                grow_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_take)
            begin
                case (paddr[3:2])
                    REG_BASE:   base_reg <= pwdata;
                    REG_MAXPG:  maxpg_reg <= pwdata[3:0];
                    REG_GROWTH: growth_en_reg <= pwdata[0];
                    default: ;
                endcase
            end
            if (cfg_init)
            begin
                init_cnt_reg <= '0;
                for (int s = 0; s < FRAME_SLOTS; s++)
                begin
                    count_reg[s] <= CNT_W'(1);
                    rec_reg[s]   <= 1'b0;
                    used_reg[s]  <= '0;
                    grow_reg[s]  <= '0;
                end
            end
            else if (state_reg == S_INIT)
                init_cnt_reg <= init_cnt_reg + 1'b1;
            if (state_reg == S_DEC && slot_ok && cur_reg.cmd == CMD_BEGIN
                && !(cur_reg.req_size == '0 && cur_reg.cmd == CMD_RESERVE))
            begin
                used_reg[slot_reg] <= '0;
                grow_reg[slot_reg] <= '0;
                rec_reg[slot_reg]  <= 1'b1;
            end
            if (state_reg == S_DEC && slot_ok && cur_reg.cmd == CMD_END)
                rec_reg[slot_reg] <= 1'b0;
            if (state_reg == S_FIT && fits)
                used_reg[slot_reg] <= used_reg[slot_reg]
                    + SUM_W'(off_full + HEAD_W'(cur_reg.req_size) - head_reg);
            if (state_reg == S_GROW && growth_en_reg && count_reg[slot_reg] < eff_max)
            begin
                count_reg[slot_reg] <= count_reg[slot_reg] + 1'b1;
                grow_reg[slot_reg]  <= grow_reg[slot_reg] + 1'b1;
                used_reg[slot_reg]  <= used_reg[slot_reg] + SUM_W'(cur_reg.req_size);
            end
        end
    end

    // head/capacity memories and datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
            for (int s = 0; s < FRAME_SLOTS; s++)
            begin
                head_mem[ENT_W'({SLOT_W'(s), init_cnt_reg[PAGE_W-1:0]})] <= '0;
                cap_mem[ENT_W'({SLOT_W'(s), init_cnt_reg[PAGE_W-1:0]})] <=
                    (init_cnt_reg == '0) ? eff_base : '0;
            end
        if (state_reg == S_IDLE && req.valid && req.ready)
        begin
            cur_reg  <= req.data;
            slot_reg <= SLOT_W'(req.data.frame);
        end
        if (state_reg == S_DEC)
        begin
            pg_reg  <= '0;
            sum_reg <= '0;
            out_reg <= {dec_status, ($bits(rsp_t) - 3)'(0)};
        end
        if (state_reg == S_DEC && slot_ok && cur_reg.cmd == CMD_BEGIN)
            for (int p = 0; p < MAX_PAGES_PER_SLOT; p++)
                head_mem[ENT_W'({slot_reg, PAGE_W'(p)})] <= '0;
        if (state_reg == S_LOAD)
        begin
            head_reg <= head_mem[ent_idx];
            cap_reg  <= cap_mem[ent_idx];
            dvd_reg  <= {head_mem[ent_idx], {ALIGN_W{1'b0}}};
            rem_reg  <= '0;
            bit_reg  <= 6'(HEAD_W - 1);
        end
        if (state_reg == S_REM)
        begin
            rem_reg <= sub_d[HEAD_W] ? rem_shift : sub_d[HEAD_W-1:0];
            dvd_reg <= dvd_reg << 1;
            bit_reg <= bit_reg - 1'b1;
        end
        if (state_reg == S_FIT)
        begin
            if (fits)
            begin
                head_mem[ent_idx] <= HEAD_W'(off_full + HEAD_W'(cur_reg.req_size));
                out_reg.page_index <= 3'(pg_reg);
                out_reg.offset <= off_full[31:0];
                pg_reg <= '0;
            end
            else if (pg_reg + 1'b1 < count_reg[slot_reg])
                pg_reg <= pg_reg + 1'b1;
            else
                pg_reg <= '0;
        end
        if (state_reg == S_GROW)
        begin
            pg_reg <= '0;
            if (growth_en_reg && count_reg[slot_reg] < eff_max)
            begin
                cap_mem[ENT_W'({slot_reg, count_reg[slot_reg][PAGE_W-1:0]})] <= new_cap;
                head_mem[ENT_W'({slot_reg, count_reg[slot_reg][PAGE_W-1:0]})] <=
                    HEAD_W'(cur_reg.req_size);
                out_reg.page_index <= 3'(count_reg[slot_reg]);
                out_reg.grew <= 1'b1;
            end
            else
                out_reg.status <= ST_EXHAUSTED;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= sum_reg + SUM_W'(cap_mem[ent_idx]);
            pg_reg  <= pg_reg + 1'b1;
            if (pg_reg + 1'b1 >= count_reg[slot_reg])
            begin
                out_reg.capacity_total <= sum_reg + SUM_W'(cap_mem[ent_idx]);
                out_reg.used_total     <= used_reg[slot_reg];
                out_reg.pages_held     <= 4'(count_reg[slot_reg]);
                out_reg.growth_events  <= grow_reg[slot_reg];
            end
        end
    end
endmodule

### hdl/psba_checker.sv
// Checker: port-level properties of the allocator, bound to the top level
module psba_checker
    import psba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status <= ST_BAD_FRAME) else $error("bad status");
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK
        |-> rsp_data.grew == 1'b0 && rsp_data.offset == '0)
        else $error("failed word carries grant");
endmodule

bind paged_staging_bump_allocator psba_checker u_psba_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

### sim/psba_checker.sv
// Checker: predicts allocator responses from observed requests and compares them
`timescale 1ns / 1ps
module psba_scoreboard
    import psba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    psba_req_if         req,
    psba_rsp_if         rsp,
    output int          errors,
    output int          pending
);
    logic [63:0] head [FRAME_SLOTS][MAX_PAGES_PER_SLOT];
    logic [63:0] cap  [FRAME_SLOTS][MAX_PAGES_PER_SLOT];
    int unsigned npages  [FRAME_SLOTS];
    int unsigned ngrowth [FRAME_SLOTS];
    bit          rec     [FRAME_SLOTS];
    logic [63:0] used    [FRAME_SLOTS];

    logic [63:0] base_size;
    int unsigned max_pg;
    bit          grow_en;

    rsp_t expected_rsp_q [$];

    function automatic logic [63:0] eff_base();
        return (base_size == 0) ? 64'd1 : base_size;
    endfunction

    function automatic int unsigned eff_max();
        int unsigned m;
        m = max_pg;
        if (m == 0) m = 1;
        if (m > MAX_PAGES_PER_SLOT) m = MAX_PAGES_PER_SLOT;
        return m;
    endfunction

    function automatic void clear_slots();
        for (int s = 0; s < FRAME_SLOTS; s++) begin
            for (int p = 0; p < MAX_PAGES_PER_SLOT; p++) begin
                head[s][p] = 0;
                cap[s][p]  = 0;
            end
            cap[s][0]  = eff_base();
            npages[s]  = 1;
            rec[s]     = 0;
            used[s]    = 0;
            ngrowth[s] = 0;
        end
    endfunction

    function automatic rsp_t alloc_result(req_t r);
        rsp_t        o;
        logic [63:0] size, align, off, nc, prev, sum, rem;
        int unsigned s, p;
        bit          ok, found;
        status_t     st;
        size  = {32'd0, r.req_size};
        align = (r.req_align == 0) ? 64'd1 : {47'd0, r.req_align};
        ok    = r.frame < FRAME_SLOTS;
        s     = ok ? r.frame : 0;
        st    = ST_OK;
        o     = '0;
        found = 0;
        p     = 0;
        off   = 0;
        if (r.cmd == CMD_RESERVE && size == 0) st = ST_ZERO_SIZE;
        else if (!ok) st = ST_BAD_FRAME;
        else if (r.cmd == CMD_BEGIN) begin
            for (int k = 0; k < MAX_PAGES_PER_SLOT; k++) head[s][k] = 0;
            used[s]    = 0;
            ngrowth[s] = 0;
            rec[s]     = 1;
        end else if (r.cmd == CMD_END) begin
            if (!rec[s]) st = ST_NOT_REC;
            else rec[s] = 0;
        end else if (r.cmd == CMD_RESERVE) begin
            if (!rec[s]) st = ST_NOT_REC;
            else begin
                while (!found && p < npages[s]) begin
                    rem = head[s][p] % align;
                    off = (rem != 0) ? head[s][p] + (align - rem) : head[s][p];
                    if (off <= cap[s][p] && size <= cap[s][p] - off) found = 1;
                    else p++;
                end
                if (!found && grow_en && npages[s] < eff_max()) begin
                    nc = 1;
                    while (nc < size) nc = nc << 1;
                    if (nc < eff_base()) nc = eff_base();
                    p = npages[s];
                    cap[s][p]  = nc;
                    head[s][p] = 0;
                    npages[s]++;
                    ngrowth[s] = (ngrowth[s] + 1) & 4'hF;
                    o.grew = 1;
                    off    = 0;
                    found  = 1;
                end
                if (!found) st = ST_EXHAUSTED;
                else begin
                    prev       = head[s][p];
                    head[s][p] = off + size;
                    used[s]    = (used[s] + (off + size - prev)) & 64'h1F_FFFF_FFFF;
                    o.page_index = p[2:0];
                    o.offset     = off[31:0];
                end
            end
        end
        o.status = st;
        if (ok) begin
            sum = 0;
            for (int k = 0; k < npages[s]; k++) sum += cap[s][k];
            o.used_total     = used[s][36:0];
            o.pages_held     = npages[s][3:0];
            o.capacity_total = sum[36:0];
            o.growth_events  = ngrowth[s][3:0];
        end else begin
            o.page_index = 0;
            o.offset     = 0;
            o.grew       = 0;
        end
        return o;
    endfunction

    task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t e;
        if (!rst_n) begin
            base_size = 65536;
            max_pg    = 8;
            grow_en   = 1;
            clear_slots();
            expected_rsp_q.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_BASE:   base_size = {32'd0, pwdata};
                    REG_MAXPG:  max_pg    = pwdata[3:0];
                    REG_GROWTH: grow_en   = pwdata[0];
                    default:    ;
                endcase
                if (paddr[3:2] != 2'd3) clear_slots();
            end
            if (rsp.valid && rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: unexpected response word, expected none, got %h",
                             $time, rsp.data);
                    errors++;
                end else begin
                    e = expected_rsp_q.pop_front();
                    check_field("status",         e.status,         rsp.data.status);
                    check_field("page_index",     e.page_index,     rsp.data.page_index);
                    check_field("offset",         e.offset,         rsp.data.offset);
                    check_field("grew",           e.grew,           rsp.data.grew);
                    check_field("used_total",     e.used_total,     rsp.data.used_total);
                    check_field("pages_held",     e.pages_held,     rsp.data.pages_held);
                    check_field("capacity_total", e.capacity_total, rsp.data.capacity_total);
                    check_field("growth_events",  e.growth_events,  rsp.data.growth_events);
                end
            end
            if (req.valid && req.ready)
                expected_rsp_q.insert(expected_rsp_q.size(), alloc_result(req.data));
            pending = expected_rsp_q.size();
        end
    end
endmodule

### sim/testbench.sv
// Testbench top: clock, reset, APB setup, request stimulus and verdict
`timescale 1ns / 1ps
module testbench;
    import psba_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    bit          quiet = 0;
    int          stall_left = 0;

    psba_req_if req ();
    psba_rsp_if rsp ();

    paged_staging_bump_allocator u_dut (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .req(req.sink), .rsp(rsp.source)
    );

    psba_scoreboard u_chk (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .req(req), .rsp(rsp), .errors, .pending
    );

    always #2 clk = ~clk;

    initial begin
        req.valid = 0;
        req.data  = '0;
        rsp.ready = 0;
    end

    // response side back-pressure
    always @(negedge clk) begin
        if (stall_left > 0) begin
            rsp.ready <= 0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp.ready <= 0;
            stall_left <= $urandom_range(0, 11);
        end else rsp.ready <= 1;
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic send_word(cmd_t c, int unsigned f, logic [31:0] sz, logic [16:0] al);
        req_t r;
        if (!quiet && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
        r.cmd = c; r.frame = f[2:0]; r.req_size = sz; r.req_align = al;
        req.valid = 1;
        req.data  = r;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
        req.valid = 0;
    endtask

    task automatic random_word();
        int unsigned k, f;
        logic [31:0] sz;
        logic [16:0] al;
        cmd_t        c;
        k = $urandom_range(0, 99);
        if (k < 10) c = CMD_BEGIN;
        else if (k < 92) c = CMD_RESERVE;
        else if (k < 97) c = CMD_END;
        else c = CMD_NONE;
        f = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: sz = $urandom_range(1, 512);
            4, 5:       sz = $urandom_range(1, 70000);
            6:          sz = $urandom;
            7:          sz = 32'd1 << $urandom_range(0, 31);
            8:          sz = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            default:    sz = $urandom_range(1, 300);
        endcase
        case ($urandom_range(0, 4))
            0:       al = 0;
            1:       al = 17'd1 << $urandom_range(0, 16);
            2:       al = $urandom_range(1, 65536);
            3:       al = $urandom_range(1, 24);
            default: al = 17'd65535;
        endcase
        send_word(c, f, sz, al);
    endtask

    initial begin
        logic [31:0] bases [8] = '{65536, 0, 1, 32'hFFFF_FFFF, 256, 4096, 64, 1000};
        logic [3:0]  maxes [8] = '{8, 1, 8, 15, 3, 0, 8, 2};
        bit          grows [8] = '{1, 0, 1, 1, 1, 0, 1, 1};
        repeat (8) @(negedge clk);
        rst_n = 1;
        repeat (20) @(negedge clk);

        // directed part on reset configuration
        send_word(CMD_RESERVE, 0, 32'd0, 0);        // zero size
        send_word(CMD_RESERVE, 1, 32'd16, 0);       // not recording
        send_word(CMD_END, 1, 32'd0, 0);            // end on idle slot
        send_word(CMD_BEGIN, 5, 32'd0, 0);          // bad frame
        send_word(CMD_RESERVE, 7, 32'd0, 0);        // zero size on bad frame
        send_word(CMD_BEGIN, 0, 32'd0, 0);
        send_word(CMD_RESERVE, 0, 32'd100, 0);
        send_word(CMD_RESERVE, 0, 32'd1, 17'd65536);
        send_word(CMD_RESERVE, 0, 32'd3, 17'd7);    // non power of two
        send_word(CMD_RESERVE, 0, 32'hFFFF_FFFF, 17'd1);
        send_word(CMD_RESERVE, 0, 32'd65536, 17'd65535);
        send_word(CMD_NONE, 0, 32'd5, 17'd3);
        send_word(CMD_BEGIN, 0, 32'd0, 0);          // restart while recording
        send_word(CMD_RESERVE, 0, 32'd70000, 17'd1);
        send_word(CMD_END, 0, 32'd0, 0);
        send_word(CMD_END, 0, 32'd0, 0);
        send_word(CMD_BEGIN, 1, 32'hFFFF_FFFF, 17'h1FFFF);
        for (int i = 0; i < 9; i++) send_word(CMD_RESERVE, 1, 32'h8000_0000, 17'd3);
        send_word(CMD_RESERVE, 1, 32'd8, 17'd0);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            reg_write(REG_BASE, bases[ph]);
            reg_write(REG_MAXPG, maxes[ph]);
            reg_write(REG_GROWTH, grows[ph]);
            send_word(CMD_BEGIN, 0, 32'd0, 0);
            send_word(CMD_BEGIN, 1, 32'd0, 0);
            for (int i = 0; i < 108; i++) begin
                if (ph == 7 && i > 20) quiet = 1;
                random_word();
            end
        end

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0 && pending == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule
